// ===== design/mtg_pkg.sv =====
// constants, types and word functions shared by the mt19937 generator
package mtg_pkg;

  localparam int unsigned STATE_WORDS_DEF = 624;
  localparam int unsigned TWIST_OFFSET    = 397;

  localparam logic [31:0] SEED_MULT    = 32'd1812433253;
  localparam logic [31:0] DEFAULT_SEED = 32'd5489;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS     = 32'h7FFF_FFFF;
  localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;

  typedef enum logic {
    ST_IDLE,
    ST_FILL
  } state_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic shift;   // every cell takes its neighbour's word
    logic fill;    // tail gets the seeding recurrence, not a twisted word
    logic first;   // first fill beat: tail gets the seed itself
    logic start;   // capture the seed for a new fill
  } ctl_t;

  function automatic logic [31:0] twist_word(input logic [31:0] head,
                                             input logic [31:0] nxt,
                                             input logic [31:0] far);
    logic [31:0] y;
    logic [31:0] v;
    y = (head & HIGH_BIT) | (nxt & LOW_BITS);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ TWIST_MATRIX;
    end
    return v;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// ===== design/mtg_cell.sv =====
// one word cell of the state chain
module mtg_cell (
  input  logic        clk,
  input  logic        shift,
  input  logic [31:0] d,
  output logic [31:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

// ===== design/mtg_chain.sv =====
// ring of word cells holding the generator state, head at cell zero
module mtg_chain #(
  parameter int unsigned WORDS  = mtg_pkg::STATE_WORDS_DEF,
  parameter int unsigned OFFSET = mtg_pkg::TWIST_OFFSET
) (
  input  logic        clk,
  input  logic        shift,
  input  logic [31:0] tail_in,
  output logic [31:0] head,
  output logic [31:0] nxt,
  output logic [31:0] far,
  output logic [31:0] tail
);

  logic [31:0] word [WORDS];

  for (genvar i = 0; i < WORDS; i++) begin : g_cell
    logic [31:0] d;
    if (i == WORDS - 1) begin : g_tail
      assign d = tail_in;
    end else begin : g_body
      assign d = word[i + 1];
    end
    mtg_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d     (d),
      .q     (word[i])
    );
  end

  assign head = word[0];
  assign nxt  = word[1];
  assign far  = word[OFFSET];
  assign tail = word[WORDS - 1];

endmodule

// ===== design/mtg_ctrl.sv =====
// sequencer: seeding sweep, self-seed and command handshake
module mtg_ctrl #(
  parameter int unsigned WORDS = mtg_pkg::STATE_WORDS_DEF,
  localparam int unsigned IDX_W = $clog2(WORDS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  logic             func,
  input  logic             step_ok,
  output logic             cmd_ready,
  output mtg_pkg::ctl_t    ctl,
  output logic [IDX_W-1:0] fill_idx
);

  import mtg_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS - 1);

  state_t state;
  state_t state_next;
  logic   seeded;
  logic   start_fill;
  logic   step;

  assign start_fill = (state == ST_IDLE) && cmd_valid && (func || !seeded);
  assign step       = (state == ST_IDLE) && cmd_valid && !func && seeded && step_ok;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start_fill) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (fill_idx == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    ctl       = '0;
    unique case (state)
      ST_IDLE: begin
        // a next beat before any seed waits for the self-seed sweep
        cmd_ready = func || (seeded && step_ok);
        ctl.start = start_fill;
        ctl.shift = step;
      end
      ST_FILL: begin
        ctl.shift = 1'b1;
        ctl.fill  = 1'b1;
        ctl.first = (fill_idx == '0);
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      seeded   <= 1'b0;
      fill_idx <= '0;
    end else begin
      state <= state_next;
      if (start_fill) begin
        fill_idx <= '0;
      end else if (state == ST_FILL) begin
        fill_idx <= fill_idx + 1'b1;
        if (fill_idx == LAST_IDX) begin
          seeded <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== design/mt19937_generator.sv =====
// a next beat's word shows the cycle after acceptance; one word per cycle with word_ready high
// the ring of word cells twists one word per next beat, so no whole-table twist stall
// a seed beat runs the seeding recurrence, which fills one cell per cycle through
// one 32x32 multiply; the first next beat before any seed triggers that sweep with 5489
// reset clears the sequencer and output valid only; the word cells are not cleared
module mt19937_generator #(
  parameter int unsigned STATE_WORDS = mtg_pkg::STATE_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  logic        func,
  input  logic [31:0] seed_value,
  output logic        word_valid,
  input  logic        word_ready,
  output logic [31:0] random_word
);

  import mtg_pkg::*;

  localparam int unsigned IDX_W = $clog2(STATE_WORDS);

  ctl_t             ctl;
  logic [IDX_W-1:0] fill_idx;
  logic             step_ok;
  logic [31:0]      seed;
  logic [31:0]      head;
  logic [31:0]      nxt;
  logic [31:0]      far;
  logic [31:0]      tail;
  logic [31:0]      twisted;
  logic [31:0]      mix;
  logic [31:0]      seeded_word;
  logic [31:0]      tail_in;

  assign step_ok = !word_valid || word_ready;

  mtg_ctrl #(
    .WORDS (STATE_WORDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .func      (func),
    .step_ok   (step_ok),
    .cmd_ready (cmd_ready),
    .ctl       (ctl),
    .fill_idx  (fill_idx)
  );

  mtg_chain #(
    .WORDS  (STATE_WORDS),
    .OFFSET (TWIST_OFFSET)
  ) u_chain (
    .clk     (clk),
    .shift   (ctl.shift),
    .tail_in (tail_in),
    .head    (head),
    .nxt     (nxt),
    .far     (far),
    .tail    (tail)
  );

  // tail holds the word pushed on the previous fill beat
  assign mix         = tail ^ (tail >> 30);
  assign seeded_word = (SEED_MULT * mix) + 32'(fill_idx);
  assign twisted     = twist_word(head, nxt, far);

  always_comb begin
    if (!ctl.fill) begin
      tail_in = twisted;
    end else if (ctl.first) begin
      tail_in = seed;
    end else begin
      tail_in = seeded_word;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      seed <= func ? seed_value : DEFAULT_SEED;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift && !ctl.fill) begin
      random_word <= temper(twisted);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (ctl.shift && !ctl.fill) begin
      word_valid <= 1'b1;
    end else if (word_ready) begin
      word_valid <= 1'b0;
    end
  end

endmodule
